>>> rtl/awu_pkg.sv
// Shared types, constants and step functions for the Adam weight update block.
// No dependencies; every other file in rtl/ imports this package.
package awu_pkg;

  // Moment store geometry; the entry count must be a power of two.
  localparam int NUM_PARAMS = 65536;
  localparam int SLOT_W     = $clog2(NUM_PARAMS);
  typedef logic [SLOT_W-1:0] slot_t;

  // Fraction bits of the Q8.24 format.
  localparam int FRAC_W = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_L1  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DECOUPLED   = 3'd7;

  localparam logic [23:0] RST_STEP_RATE   = 24'd16777;
  localparam logic [15:0] RST_BETA_FIRST  = 16'd58982;
  localparam logic [15:0] RST_BETA_SECOND = 16'd65470;
  localparam logic [23:0] RST_DECAY_RATE  = 24'd0;
  localparam logic [24:0] RST_GRAD_SCALE  = 25'd16777216;
  localparam logic [15:0] RST_EPSILON     = 16'd16;

  typedef struct packed {
    logic [23:0] step_rate;
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [23:0] decay_rate;
    logic [24:0] grad_scale;
    logic [15:0] epsilon;
    logic        penalty_l1;
    logic        decoupled_decay;
  } cfg_t;

  // Per-item values that ride along the root and divide pipelines.
  typedef struct packed {
    logic [15:0]        idx;
    logic signed [31:0] w;
    logic signed [33:0] pen;
    logic signed [31:0] m1;
    logic               sat;
  } side_t;

  // Front end to moment stage.
  typedef struct packed {
    logic               vld;
    logic [15:0]        idx;
    logic signed [31:0] w;
    logic signed [33:0] pen;
    logic signed [49:0] tm1;
    logic [55:0]        tm2;
  } mom_in_t;

  // Moment stage to square root.
  typedef struct packed {
    logic        vld;
    logic [31:0] m2;
    side_t       side;
  } mom_out_t;

  // Square root pipeline: two result bits per stage.
  localparam int SQ_ROOT_W = 28;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;
  localparam int SQ_PER    = 2;
  localparam int SQ_ST     = SQ_ROOT_W / SQ_PER;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_RAD_W-1:0]  rad;
  } sq_st_t;

  typedef struct packed {
    logic                 vld;
    logic [SQ_ROOT_W-1:0] root;
    side_t                side;
  } sq_out_t;

  // Divide pipeline: two quotient bits per stage.
  localparam int DV_NUM_W = 56;
  localparam int DV_DEN_W = 29;
  localparam int DV_PER   = 2;
  localparam int DV_ST    = DV_NUM_W / DV_PER;

  typedef struct packed {
    logic [DV_NUM_W-1:0] nq;
    logic [DV_DEN_W-1:0] rem;
    logic [DV_DEN_W-1:0] den;
  } dv_st_t;

  typedef struct packed {
    logic                vld;
    logic [DV_NUM_W-1:0] quot;
    logic                neg;
    side_t               side;
  } dv_out_t;

  // Result item.
  typedef struct packed {
    logic [15:0]        idx;
    logic signed [31:0] nw;
    logic               sat;
  } res_t;

  // Items the block can hold: front 5, moment 2, root, divide entry and
  // stages, post 3, output register and skid register.
  localparam int AWU_DEPTH = 5 + 2 + SQ_ST + 1 + DV_ST + 3 + 2;

  // Digit-by-digit square root, SQ_PER result bits.
  function automatic sq_st_t sqrt_step(sq_st_t s);
    sq_st_t              r;
    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] trial;
    r = s;
    for (int k = 0; k < SQ_PER; k++) begin
      acc   = {r.rem, r.rad[SQ_RAD_W-1 -: 2]};
      trial = {2'b00, r.root, 2'b01};
      r.rad = {r.rad[SQ_RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
        acc    = acc - trial;
        r.root = {r.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[SQ_ROOT_W-2:0], 1'b0};
      end
      r.rem = acc[SQ_REM_W-1:0];
    end
    return r;
  endfunction

  // Restoring divide, DV_PER quotient bits shifted into the numerator word.
  function automatic dv_st_t div_step(dv_st_t s);
    dv_st_t            r;
    logic [DV_DEN_W:0] acc;
    r = s;
    for (int k = 0; k < DV_PER; k++) begin
      acc  = {r.rem, r.nq[DV_NUM_W-1]};
      r.nq = {r.nq[DV_NUM_W-2:0], 1'b0};
      if (acc >= {1'b0, r.den}) begin
        acc     = acc - {1'b0, r.den};
        r.nq[0] = 1'b1;
      end
      r.rem = acc[DV_DEN_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/awu_front.sv
// Front end: gradient scaling, weight penalty, squared gradient and the
// new-sample terms of both moments. Depends on awu_pkg.
module awu_front import awu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               take,
  input  logic [15:0]        idx,
  input  logic signed [31:0] grad,
  input  logic signed [31:0] wt,
  input  cfg_t               cfg,
  output mom_in_t            mi
);

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [15:0]        idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;
  logic signed [31:0] g1_r;
  logic signed [31:0] w1_r, w2_r, w3_r, w4_r, w5_r;
  logic               gneg2_r, wneg2_r;
  logic [56:0]        pg2_r;
  logic [55:0]        pw2_r;
  logic signed [33:0] pen3_r, pen4_r, pen5_r;
  logic signed [31:0] dw3_r;
  logic signed [49:0] tm1_4_r, tm1_5_r;
  logic [38:0]        sq4_r;
  logic [55:0]        tm2_5_r;

  logic [31:0]        gmag, wmag, dmag;
  logic [56:0]        pg_nxt;
  logic [55:0]        pw_nxt;
  logic signed [33:0] sg, pwq, pen_nxt;
  logic signed [34:0] dwr;
  logic signed [31:0] dw_nxt;
  logic [63:0]        sqf;
  logic [16:0]        omb1, omb2;
  logic signed [49:0] tm1_nxt;
  logic [55:0]        tm2_nxt;

  // Magnitude products of gradient scale and weight penalty.
  always_comb begin
    gmag   = g1_r[31] ? 32'(-g1_r) : 32'(g1_r);
    wmag   = w1_r[31] ? 32'(-w1_r) : 32'(w1_r);
    pg_nxt = 57'(gmag) * 57'(cfg.grad_scale);
    pw_nxt = 56'(wmag) * 56'(cfg.decay_rate);
  end

  // Signed scaled gradient, penalty, and the clamped gradient term.
  always_comb begin
    sg  = $signed({1'b0, pg2_r[56:FRAC_W]});
    sg  = gneg2_r ? -sg : sg;
    pwq = $signed({2'b00, pw2_r[55:FRAC_W]});
    if (cfg.penalty_l1) begin
      pen_nxt = (w2_r > 0) ? -34'(cfg.decay_rate) : 34'(cfg.decay_rate);
    end else begin
      pen_nxt = wneg2_r ? pwq : -pwq;
    end
    dwr = 35'(sg) + (cfg.decoupled_decay ? 35'sd0 : 35'(pen_nxt));
    if (dwr > 35'sd2147483647) begin
      dw_nxt = 32'sh7FFF_FFFF;
    end else if (dwr < -35'sd2147483648) begin
      dw_nxt = 32'sh8000_0000;
    end else begin
      dw_nxt = dwr[31:0];
    end
  end

  // Squared gradient and the first moment's new-sample term.
  always_comb begin
    dmag    = dw3_r[31] ? 32'(-dw3_r) : 32'(dw3_r);
    sqf     = 64'(dmag) * 64'(dmag);
    omb1    = 17'd65536 - {1'b0, cfg.beta_first};
    tm1_nxt = 50'($signed({1'b0, omb1})) * 50'(dw3_r);
  end

  // Second moment's new-sample term.
  always_comb begin
    omb2    = 17'd65536 - {1'b0, cfg.beta_second};
    tm2_nxt = 56'(omb2) * 56'(sq4_r);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r  <= idx;
      g1_r    <= grad;
      w1_r    <= wt;
      idx2_r  <= idx1_r;
      w2_r    <= w1_r;
      gneg2_r <= g1_r[31];
      wneg2_r <= w1_r[31];
      pg2_r   <= pg_nxt;
      pw2_r   <= pw_nxt;
      idx3_r  <= idx2_r;
      w3_r    <= w2_r;
      pen3_r  <= pen_nxt;
      dw3_r   <= dw_nxt;
      idx4_r  <= idx3_r;
      w4_r    <= w3_r;
      pen4_r  <= pen3_r;
      tm1_4_r <= tm1_nxt;
      sq4_r   <= sqf[62:FRAC_W];
      idx5_r  <= idx4_r;
      w5_r    <= w4_r;
      pen5_r  <= pen4_r;
      tm1_5_r <= tm1_4_r;
      tm2_5_r <= tm2_nxt;
    end
  end

  assign mi = '{vld: v5_r, idx: idx5_r, w: w5_r, pen: pen5_r,
                tm1: tm1_5_r, tm2: tm2_5_r};

endmodule

>>> rtl/awu_moment.sv
// Moment stores with read-modify-write, forwarding and the clearing pass
// after reset. Depends on awu_pkg.
module awu_moment import awu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  cfg_t     cfg,
  input  mom_in_t  mi,
  output mom_out_t mo,
  output logic     clearing
);

  logic [31:0] m1_mem [NUM_PARAMS];
  logic [31:0] m2_mem [NUM_PARAMS];

  logic        clearing_r;
  slot_t       clr_addr_r;
  logic        kv_r;
  mom_in_t     k_r;
  logic [31:0] rd1_r, rd2_r;
  logic        mo_v_r;
  logic [31:0] mo_m2_r;
  side_t       mo_side_r;

  slot_t              rd_slot, k_slot, fwd_slot;
  logic               fwd_hit;
  logic signed [31:0] old1, m1_new;
  logic [31:0]        old2, m2_new;
  logic signed [50:0] s1, s1a;
  logic signed [34:0] q1;
  logic [56:0]        s2;
  logic [40:0]        q2;
  logic               sat1, sat2;

  assign rd_slot  = slot_t'(mi.idx);
  assign k_slot   = slot_t'(k_r.idx);
  assign fwd_slot = slot_t'(mo_side_r.idx);

  // The previous item wrote at the edge this item's read was taken.
  assign fwd_hit = mo_v_r && (fwd_slot == k_slot);

  // Moment updates with truncating divide by 2^16 and saturation.
  always_comb begin
    old1 = fwd_hit ? mo_side_r.m1 : $signed(rd1_r);
    old2 = fwd_hit ? mo_m2_r : rd2_r;
    s1   = 51'($signed({1'b0, cfg.beta_first})) * 51'(old1) + 51'(k_r.tm1);
    s1a  = s1 + (s1[50] ? 51'sd65535 : 51'sd0);
    q1   = s1a[50:16];
    sat1 = 1'b0;
    if (q1 > 35'sd2147483647) begin
      m1_new = 32'sh7FFF_FFFF;
      sat1   = 1'b1;
    end else if (q1 < -35'sd2147483648) begin
      m1_new = 32'sh8000_0000;
      sat1   = 1'b1;
    end else begin
      m1_new = q1[31:0];
    end
    s2     = 57'(cfg.beta_second) * 57'(old2) + 57'(k_r.tm2);
    q2     = s2[56:16];
    sat2   = |q2[40:32];
    m2_new = sat2 ? 32'hFFFF_FFFF : q2[31:0];
  end

  // Clearing pass: one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      m1_mem[clr_addr_r] <= '0;
      m2_mem[clr_addr_r] <= '0;
    end else if (adv && kv_r) begin
      m1_mem[k_slot] <= m1_new;
      m2_mem[k_slot] <= m2_new;
    end
    if (adv) begin
      rd1_r <= m1_mem[rd_slot];
      rd2_r <= m2_mem[rd_slot];
    end
  end

  // Update and output stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r   <= 1'b0;
      mo_v_r <= 1'b0;
    end else if (adv) begin
      kv_r   <= mi.vld;
      mo_v_r <= kv_r;
    end
  end

  // Update and output stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      k_r       <= mi;
      mo_m2_r   <= m2_new;
      mo_side_r <= '{idx: k_r.idx, w: k_r.w, pen: k_r.pen, m1: m1_new,
                     sat: sat1 || sat2};
    end
  end

  assign mo       = '{vld: mo_v_r, m2: mo_m2_r, side: mo_side_r};
  assign clearing = clearing_r;

endmodule

>>> rtl/awu_sqrt.sv
// Pipelined integer square root of the second moment scaled by 2^24.
// Depends on awu_pkg (sqrt_step).
module awu_sqrt import awu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  mom_out_t mo,
  output sq_out_t  so
);

  logic   vld_r  [SQ_ST];
  sq_st_t st_r   [SQ_ST];
  side_t  side_r [SQ_ST];

  logic   vin  [SQ_ST];
  sq_st_t stin [SQ_ST];
  side_t  sin  [SQ_ST];

  // Stage inputs: the first stage takes the moment result.
  always_comb begin
    vin[0]  = mo.vld;
    stin[0] = '{rem: '0, root: '0, rad: {mo.m2, {FRAC_W{1'b0}}}};
    sin[0]  = mo.side;
    for (int s = 1; s < SQ_ST; s++) begin
      vin[s]  = vld_r[s-1];
      stin[s] = st_r[s-1];
      sin[s]  = side_r[s-1];
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SQ_ST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      for (int s = 0; s < SQ_ST; s++) begin
        vld_r[s] <= vin[s];
      end
    end
  end

  // Two root bits per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < SQ_ST; s++) begin
        st_r[s]   <= sqrt_step(stin[s]);
        side_r[s] <= sin[s];
      end
    end
  end

  assign so = '{vld: vld_r[SQ_ST-1], root: st_r[SQ_ST-1].root,
                side: side_r[SQ_ST-1]};

endmodule

>>> rtl/awu_div.sv
// Pipelined signed divide of the first moment (scaled by 2^24) by
// epsilon plus the root. Depends on awu_pkg (div_step).
module awu_div import awu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  cfg_t    cfg,
  input  sq_out_t so,
  output dv_out_t dv
);

  logic   e_v_r;
  dv_st_t e_st_r;
  logic   e_neg_r;
  side_t  e_side_r;

  logic   vld_r  [DV_ST];
  dv_st_t st_r   [DV_ST];
  logic   neg_r  [DV_ST];
  side_t  side_r [DV_ST];

  logic   vin  [DV_ST];
  dv_st_t stin [DV_ST];
  logic   nin  [DV_ST];
  side_t  sin  [DV_ST];

  logic [DV_DEN_W-1:0] den_sum, den;
  logic [31:0]         mag1;

  // Denominator, with zero taken as one, and numerator magnitude.
  always_comb begin
    den_sum = DV_DEN_W'(cfg.epsilon) + DV_DEN_W'(so.root);
    den     = (den_sum == '0) ? DV_DEN_W'(1) : den_sum;
    mag1    = so.side.m1[31] ? 32'(-so.side.m1) : 32'(so.side.m1);
  end

  // Stage inputs.
  always_comb begin
    vin[0]  = e_v_r;
    stin[0] = e_st_r;
    nin[0]  = e_neg_r;
    sin[0]  = e_side_r;
    for (int s = 1; s < DV_ST; s++) begin
      vin[s]  = vld_r[s-1];
      stin[s] = st_r[s-1];
      nin[s]  = neg_r[s-1];
      sin[s]  = side_r[s-1];
    end
  end

  // Valids of the entry stage and the divide stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      for (int s = 0; s < DV_ST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      e_v_r <= so.vld;
      for (int s = 0; s < DV_ST; s++) begin
        vld_r[s] <= vin[s];
      end
    end
  end

  // Two quotient bits per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      e_st_r   <= '{nq: {mag1, {FRAC_W{1'b0}}}, rem: '0, den: den};
      e_neg_r  <= so.side.m1[31];
      e_side_r <= so.side;
      for (int s = 0; s < DV_ST; s++) begin
        st_r[s]   <= div_step(stin[s]);
        neg_r[s]  <= nin[s];
        side_r[s] <= sin[s];
      end
    end
  end

  assign dv = '{vld: vld_r[DV_ST-1], quot: st_r[DV_ST-1].nq,
                neg: neg_r[DV_ST-1], side: side_r[DV_ST-1]};

endmodule

>>> rtl/adam_weight_update_top.sv
// Inputs pass the front, moment, root, divide and post stages to out_valid.
// Throughput: one transaction per cycle while in_stall is low; the moment store
// read-modify-write forwards results, so repeated indexes run back to back.
// Reset: synchronous, active low; it then clears 65536 moment entries, one per
// cycle, with in_stall high, and restores the register reset values.
module adam_weight_update_top import awu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_param_index,
  input  logic signed [31:0]    in_gradient,
  input  logic signed [31:0]    in_weight,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_index,
  output logic signed [31:0]    out_new_weight,
  output logic                  out_saturated,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  mom_in_t  mi;
  mom_out_t mo;
  sq_out_t  so;
  dv_out_t  dv;
  logic     clearing, adv, take;

  logic               p1_v_r, p2_v_r, p3_v_r;
  logic [55:0]        p1_mag_r;
  logic               p1_neg_r, p2_neg_r, p3_neg_r;
  logic signed [31:0] p1_w_r, p2_w_r, p3_w_r;
  logic               p1_sat_r, p2_sat_r, p3_sat_r;
  logic [15:0]        p1_idx_r, p2_idx_r, p3_idx_r;
  logic [47:0]        p2_lo_r;
  logic [31:0]        p2_hi_r;
  logic [56:0]        p3_t_r;

  logic               out_v_r, skid_v_r;
  res_t               out_r, skid_r, res;

  logic signed [57:0] rq, r;
  logic [55:0]        rmag;
  logic [47:0]        lo_nxt;
  logic [56:0]        t_nxt;
  logic signed [58:0] tv, nwf;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r || clearing;
  assign take     = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{step_rate: RST_STEP_RATE, beta_first: RST_BETA_FIRST,
                 beta_second: RST_BETA_SECOND, decay_rate: RST_DECAY_RATE,
                 grad_scale: RST_GRAD_SCALE, epsilon: RST_EPSILON,
                 penalty_l1: 1'b0, decoupled_decay: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_RATE:   cfg_r.step_rate       <= cfg_wdata[23:0];
        REG_BETA_FIRST:  cfg_r.beta_first      <= cfg_wdata[15:0];
        REG_BETA_SECOND: cfg_r.beta_second     <= cfg_wdata[15:0];
        REG_DECAY_RATE:  cfg_r.decay_rate      <= cfg_wdata[23:0];
        REG_GRAD_SCALE:  cfg_r.grad_scale      <= cfg_wdata[24:0];
        REG_EPSILON:     cfg_r.epsilon         <= cfg_wdata[15:0];
        REG_PENALTY_L1:  cfg_r.penalty_l1      <= cfg_wdata[0];
        REG_DECOUPLED:   cfg_r.decoupled_decay <= cfg_wdata[0];
        default:         cfg_r                 <= cfg_r;
      endcase
    end
  end

  awu_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .take  (take),
    .idx   (in_param_index),
    .grad  (in_gradient),
    .wt    (in_weight),
    .cfg   (cfg_r),
    .mi    (mi)
  );

  awu_moment u_moment (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cfg      (cfg_r),
    .mi       (mi),
    .mo       (mo),
    .clearing (clearing)
  );

  awu_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .mo    (mo),
    .so    (so)
  );

  awu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg_r),
    .so    (so),
    .dv    (dv)
  );

  // Signed ratio plus the decoupled penalty, as sign and magnitude.
  always_comb begin
    rq   = dv.neg ? -$signed({2'b00, dv.quot}) : $signed({2'b00, dv.quot});
    r    = rq + (cfg_r.decoupled_decay ? 58'(dv.side.pen) : 58'sd0);
    rmag = r[57] ? 56'(-r) : 56'(r);
  end

  // Step rate product split into a low and a high partial product.
  always_comb begin
    lo_nxt = 48'(p1_mag_r[FRAC_W-1:0]) * 48'(cfg_r.step_rate);
    t_nxt  = 57'(p2_hi_r) * 57'(cfg_r.step_rate) + 57'(p2_lo_r[47:FRAC_W]);
  end

  // New weight with saturation.
  always_comb begin
    tv      = $signed({2'b00, p3_t_r});
    nwf     = 59'(p3_w_r) + (p3_neg_r ? -tv : tv);
    res.idx = p3_idx_r;
    res.sat = p3_sat_r;
    if (nwf > 59'sd2147483647) begin
      res.nw  = 32'sh7FFF_FFFF;
      res.sat = 1'b1;
    end else if (nwf < -59'sd2147483648) begin
      res.nw  = 32'sh8000_0000;
      res.sat = 1'b1;
    end else begin
      res.nw = nwf[31:0];
    end
  end

  // Post stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= dv.vld;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  // Post stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mag_r <= rmag;
      p1_neg_r <= r[57];
      p1_w_r   <= dv.side.w;
      p1_sat_r <= dv.side.sat;
      p1_idx_r <= dv.side.idx;
      p2_lo_r  <= lo_nxt;
      p2_hi_r  <= p1_mag_r[55:FRAC_W];
      p2_neg_r <= p1_neg_r;
      p2_w_r   <= p1_w_r;
      p2_sat_r <= p1_sat_r;
      p2_idx_r <= p1_idx_r;
      p3_t_r   <= t_nxt;
      p3_neg_r <= p2_neg_r;
      p3_w_r   <= p2_w_r;
      p3_sat_r <= p2_sat_r;
      p3_idx_r <= p2_idx_r;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (adv && p3_v_r) begin
      if (out_v_r && out_stall) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_v_r && !out_stall) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p3_v_r) begin
      if (out_v_r && out_stall) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (out_v_r && !out_stall && skid_v_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_index      = out_r.idx;
  assign out_new_weight = out_r.nw;
  assign out_saturated  = out_r.sat;

endmodule

>>> rtl/awu_checker.sv
// Port-level checks for adam_weight_update_top, attached by bind.
// Depends on awu_pkg for the block's capacity.
module awu_checker import awu_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [15:0]           in_param_index,
  input logic signed [31:0]    in_gradient,
  input logic signed [31:0]    in_weight,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [15:0]           out_index,
  input logic signed [31:0]    out_new_weight,
  input logic                  out_saturated
);

  localparam int PEND_W = $clog2(AWU_DEPTH + 1) + 1;

  logic              in_acc, out_acc;
  logic [PEND_W-1:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + PEND_W'(in_acc) - PEND_W'(out_acc);
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_param_index)
      && $stable(in_gradient) && $stable(in_weight))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index)
      && $stable(out_new_weight) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input taken during moment clearing");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result delivered without a pending transaction");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(AWU_DEPTH))
    else $error("more transactions in flight than the pipeline holds");

endmodule

bind adam_weight_update_top awu_checker u_awu_checker (.*);

>>> bench/adam_weight_update_checker.sv
// Checker for the Adam weight update block: predicts each result from the
// input transactions and compares it with the output channel.
// Depends on awu_pkg for the register index, width and reset value constants.
`timescale 1ns / 1ps

module adam_weight_update_checker import awu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [15:0]           in_param_index,
  input  logic signed [31:0]    in_gradient,
  input  logic signed [31:0]    in_weight,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [15:0]           out_index,
  input  logic signed [31:0]    out_new_weight,
  input  logic                  out_saturated,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    error_count,
  output int                    pending_count
);

  typedef struct {
    logic [15:0] idx;
    logic [31:0] nw;
    logic        sat;
  } update_t;

  update_t      pending_updates[$];
  logic [31:0]  first_moment[int];
  logic [31:0]  second_moment[int];
  logic [23:0]  lr;
  logic [15:0]  b1;
  logic [15:0]  b2;
  logic [23:0]  lambda;
  logic [24:0]  gscale;
  logic [15:0]  eps;
  logic         use_l1;
  logic         decoupled;

  // Truncating product of a signed value and a Q1.24 factor.
  function automatic longint scale_q24(longint x, longint k);
    longint mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r   = (mag >>> 24) * k + (((mag & 64'hFFFFFF) * k) >>> 24);
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint clamp32(longint v, inout logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Computes the new weight and updates the moment copies for one parameter.
  function automatic update_t predict_update(logic [15:0] idx, logic signed [31:0] g32,
                                             logic signed [31:0] w32);
    update_t         u;
    logic            sat;
    logic            ignore;
    longint          g;
    longint          w;
    longint          pen;
    longint          dw;
    longint          m1;
    longint          r;
    longint          mag;
    longint unsigned sq;
    longint unsigned m2;
    longint unsigned den;
    longint          old1;
    longint unsigned old2;
    sat    = 1'b0;
    ignore = 1'b0;
    g      = g32;
    w      = w32;
    old1   = first_moment.exists(idx) ? longint'(signed'(first_moment[idx])) : 0;
    old2   = second_moment.exists(idx) ? longint'(second_moment[idx]) : 0;
    if (use_l1) pen = (w > 0) ? -longint'(lambda) : longint'(lambda);
    else pen = -scale_q24(w, lambda);
    dw = scale_q24(g, gscale);
    if (!decoupled) dw = dw + pen;
    dw = clamp32(dw, ignore);
    m1 = (longint'(b1) * old1 + (65536 - longint'(b1)) * dw) / 65536;
    m1 = clamp32(m1, sat);
    first_moment[idx] = m1[31:0];
    mag = (dw < 0) ? -dw : dw;
    sq  = (longint'(mag) * mag) >> 24;
    m2  = (longint'(b2) * old2 + (65536 - longint'(b2)) * sq) / 65536;
    if (m2 > 64'hFFFFFFFF) begin
      m2  = 64'hFFFFFFFF;
      sat = 1'b1;
    end
    second_moment[idx] = m2[31:0];
    den = longint'(eps) + int_sqrt(m2 << 24);
    if (den == 0) den = 1;
    r = (m1 * 16777216) / longint'(den);
    if (decoupled) r = r + pen;
    u.idx = idx;
    u.nw  = 32'(clamp32(w + scale_q24(r, lr), sat));
    u.sat = sat;
    return u;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lr        <= RST_STEP_RATE;
      b1        <= RST_BETA_FIRST;
      b2        <= RST_BETA_SECOND;
      lambda    <= RST_DECAY_RATE;
      gscale    <= RST_GRAD_SCALE;
      eps       <= RST_EPSILON;
      use_l1    <= 1'b0;
      decoupled <= 1'b0;
      first_moment.delete();
      second_moment.delete();
      error_count = 0;
    end else begin
      // Register writes; extra data bits are dropped.
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_RATE:   lr        <= cfg_wdata[23:0];
          REG_BETA_FIRST:  b1        <= cfg_wdata[15:0];
          REG_BETA_SECOND: b2        <= cfg_wdata[15:0];
          REG_DECAY_RATE:  lambda    <= cfg_wdata[23:0];
          REG_GRAD_SCALE:  gscale    <= cfg_wdata[24:0];
          REG_EPSILON:     eps       <= cfg_wdata[15:0];
          REG_PENALTY_L1:  use_l1    <= cfg_wdata[0];
          REG_DECOUPLED:   decoupled <= cfg_wdata[0];
          default: ;
        endcase
      end
      // Predict on each accepted input transaction.
      if (in_valid && !in_stall)
        pending_updates.push_back(predict_update(in_param_index, in_gradient, in_weight));
      // Compare each accepted output transaction with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (pending_updates.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: index %0d weight %h sat %b",
                     out_index, out_new_weight, out_saturated);
        end else begin
          update_t u;
          u = pending_updates.pop_front();
          if (u.idx !== out_index || u.nw !== out_new_weight || u.sat !== out_saturated) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected index %0d weight %h sat %b, got %0d %h %b",
                       u.idx, u.nw, u.sat, out_index, out_new_weight, out_saturated);
          end
        end
      end
    end
    // Predictions still waiting for their result.
    pending_count = pending_updates.size();
  end

endmodule

>>> bench/adam_weight_update_top_test.sv
// Stimulus and verdict for the Adam weight update block.
// Depends on awu_pkg, adam_weight_update_top and adam_weight_update_checker.
`timescale 1ns / 1ps

module adam_weight_update_top_test;
  import awu_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_param_index;
  logic signed [31:0]    in_gradient;
  logic signed [31:0]    in_weight;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           out_index;
  logic signed [31:0]    out_new_weight;
  logic                  out_saturated;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    error_count;
  int                    pending_count;
  logic                  calm;

  adam_weight_update_top uut (.*);
  adam_weight_update_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output stall: random, 9 chances in 100, none during the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 9);
  end

  // Drives one input transaction after an optional random gap.
  task automatic send_update(logic [15:0] idx, logic [31:0] g, logic [31:0] w);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_param_index <= idx;
    in_gradient    <= g;
    in_weight      <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Writes one register; the caller drops cfg_we after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Lets the pipeline drain before touching the registers.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(33554431) - 16777216;
      2: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom())};
      default: return $urandom_range(4194303) - 2097152;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals [6];
    logic [15:0] idx;
    rst_n = 1'b0; in_valid = 1'b0; in_param_index = '0; in_gradient = '0;
    in_weight = '0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    calm = 1'b0;
    edge_vals = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h01000000,
                  32'hFF000000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes on a few indexes, including repeats.
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 3; j++)
        send_update((i % 2) ? 16'hFFFF : 16'h0000, edge_vals[i], edge_vals[(i + j * 2) % 6]);
    drain();

    // Every register written, through several settings including extremes.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_STEP_RATE, 25'h1FFFFFF);
          write_reg(REG_BETA_FIRST, 25'd0);
          write_reg(REG_BETA_SECOND, 25'd0);
          write_reg(REG_DECAY_RATE, 25'hFFFFFF);
          write_reg(REG_GRAD_SCALE, 25'd16777216);
          write_reg(REG_EPSILON, 25'd0);
          write_reg(REG_PENALTY_L1, 25'd0);
          write_reg(REG_DECOUPLED, 25'd0);
        end
        1: begin
          write_reg(REG_BETA_FIRST, 25'hFFFF);
          write_reg(REG_BETA_SECOND, 25'hFFFF);
          write_reg(REG_GRAD_SCALE, 25'd0);
          write_reg(REG_PENALTY_L1, 25'd1);
          write_reg(REG_EPSILON, 25'hFFFF);
        end
        2: begin
          write_reg(REG_DECOUPLED, 25'd1);
          write_reg(REG_GRAD_SCALE, 25'h1FFFFFF);
          write_reg(REG_BETA_FIRST, 25'd58982);
          write_reg(REG_BETA_SECOND, 25'd65470);
          write_reg(REG_EPSILON, 25'd1);
        end
        3: begin
          write_reg(REG_PENALTY_L1, 25'd0);
          write_reg(REG_STEP_RATE, 25'd0);
          write_reg(REG_DECAY_RATE, 25'd0);
        end
        default: begin
          write_reg(REG_STEP_RATE, CFG_DATA_W'($urandom()));
          write_reg(REG_BETA_FIRST, CFG_DATA_W'($urandom()));
          write_reg(REG_BETA_SECOND, CFG_DATA_W'($urandom()));
          write_reg(REG_DECAY_RATE, CFG_DATA_W'($urandom_range(1) ? $urandom()
                                                 : $urandom_range(65535)));
          write_reg(REG_GRAD_SCALE, CFG_DATA_W'($urandom_range(16777216)));
          write_reg(REG_EPSILON, CFG_DATA_W'($urandom_range(65535, 1)));
          write_reg(REG_PENALTY_L1, CFG_DATA_W'($urandom()));
          write_reg(REG_DECOUPLED, CFG_DATA_W'($urandom()));
        end
      endcase
      cfg_we <= 1'b0;
      calm = (phase == 5);
      // A few parameters are hit repeatedly so the moments accumulate.
      for (int n = 0; n < 100; n++) begin
        idx = ($urandom_range(99) < 70) ? 16'($urandom_range(7)) : 16'($urandom());
        send_update(idx, rand_word($urandom_range(3)), rand_word($urandom_range(3)));
      end
      calm = 1'b0;
      drain();
    end

    if (error_count == 0) $display("adam_weight_update_top_test: clean");
    else $display("adam_weight_update_top_test: errors");
    $finish;
  end

  // Time limit: reset clear pass plus a generous margin.
  initial begin
    #20ms;
    $display("adam_weight_update_top_test: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/awu_pkg.sv
rtl/awu_front.sv
rtl/awu_moment.sv
rtl/awu_sqrt.sv
rtl/awu_div.sv
rtl/adam_weight_update_top.sv
rtl/awu_checker.sv
bench/adam_weight_update_checker.sv
bench/adam_weight_update_top_test.sv
